// ===== rtl/sbs_pkg.sv =====
// Package for the sorted table bracket search block.
// Holds command and status codes, sequencer states and the compare flag struct.
// No dependencies.
package sbs_pkg;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 10;
  localparam int TOL_W    = 31;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_BRACKET = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABOVE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOAD_OK = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_PROBE,
    S_WALK,
    S_OUT
  } seq_state_t;

  // entry versus query compare results
  typedef struct packed {
    logic over;   // entry - query > tolerance
    logic under;  // query - entry > tolerance
    logic less;   // entry < query
  } cmp_flags_t;

endpackage

// ===== rtl/sbs_if.sv =====
// Valid/ready channel interfaces for the bracket search block.
// sbs_in_if carries command words, sbs_out_if carries result words. No dependencies.
interface sbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sbs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] lower_index;
  logic [9:0] upper_index;
  logic       matched;

  modport source (output valid, output status, output lower_index, output upper_index,
                  output matched, input ready);
  modport sink   (input valid, input status, input lower_index, input upper_index,
                  input matched, output ready);
endinterface

// ===== rtl/sbs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sbs_cmp.sv =====
// Tolerance comparator: compares one table entry against the query value.
// Depends on sbs_pkg (cmp_flags_t, TOL_W).
module sbs_cmp import sbs_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic signed [DATA_WIDTH-1:0] entry,
  input  logic signed [DATA_WIDTH-1:0] query,
  input  logic [TOL_W-1:0]             tol,
  output cmp_flags_t                   flags
);

  // wide enough for the exact difference and the tolerance
  localparam int XW = (DATA_WIDTH + 2 > TOL_W + 2) ? DATA_WIDTH + 2 : TOL_W + 2;

  logic signed [XW-1:0] entry_x;
  logic signed [XW-1:0] query_x;
  logic signed [XW-1:0] diff;
  logic signed [XW-1:0] tol_x;
  logic signed [XW-1:0] tol_neg;

  assign entry_x = XW'(entry);
  assign query_x = XW'(query);
  assign diff    = entry_x - query_x;
  assign tol_x   = $signed(XW'(tol));
  assign tol_neg = -tol_x;

  // diff against +tol and -tol in parallel
  assign flags.over  = diff > tol_x;
  assign flags.under = diff < tol_neg;
  assign flags.less  = diff[XW-1];

endmodule

// ===== rtl/sorted_table_bracket_search.sv =====
// Top level of the sorted table bracket search block: sequencer, count and tolerance.
// Depends on sbs_pkg, sbs_if (sbs_in_if, sbs_out_if), sbs_ram and sbs_cmp.
//
//  port       dir  width  role
//  in_ch      in   2+32   command word: cmd, value (valid/ready)
//  out_ch     out  3+10+10+1  result word: status, lower/upper index, matched
//  cfg_we     in   1      tolerance write strobe
//  cfg_wdata  in   31     tolerance, unsigned Q15.16
//
// Append, clear and unused commands: the accept cycle, then S_OUT loads the result into
//   the output register once it is free.
// Query: accept, first entry read, last entry read, then the binary search probes (at
//   most clog2(count)+1) and the entries checked on the walk back (each match passed plus
//   the one that ends it, none past entry 0), then S_OUT loads the result; each step is
//   one read of the entry RAM.
// Reset is synchronous, active low; it empties the table and clears tolerance. RAM
//   contents are not cleared. A new word is taken while a result waits on out_ch; the
//   next result stalls in the sequencer until the output register frees.
module sorted_table_bracket_search import sbs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  sbs_in_if.sink           in_ch,
  sbs_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  seq_state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic [TOL_W-1:0]            tol_r;
  logic signed [DATA_WIDTH-1:0] query_r, query_nxt;
  logic [CW-1:0]               lo_r, lo_nxt;
  logic [AW-1:0]               hi_r, hi_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [AW-1:0]       res_lower_r, res_lower_nxt;
  logic [AW-1:0]       res_upper_r, res_upper_nxt;
  logic                res_matched_r, res_matched_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_lower_r;
  logic [IDX_W-1:0]    out_upper_r;
  logic                out_matched_r;

  logic                  in_accept;
  logic                  out_free;
  logic signed [DATA_WIDTH+31:0] value_wide;
  logic signed [DATA_WIDTH-1:0]  value_in;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  cmp_flags_t            flags;
  logic                  tol_hit;

  // search arithmetic
  logic [CW-1:0] cnt_m1_w;
  logic [AW-1:0] hi_init;
  logic [CW:0]   sum_init, sum_right, sum_left;
  logic [CW:0]   sh_init, sh_right, sh_left;
  logic [AW-1:0] mid_init, mid_right, mid_left;
  logic [CW-1:0] lo_up;
  logic [AW-1:0] hi_dn;
  logic [AW-1:0] walk_dn;
  logic          right_end, left_end;
  logic          go_right;
  logic          table_full, table_empty;
  logic          query_go;
  logic [CW-1:0] nf_lo, nf_lo_m1;
  logic [AW-1:0] nf_lower, nf_upper;

  logic [AW+IDX_W-1:0] lower_wide, upper_wide;

  // value held at table width
  assign value_wide = {{DATA_WIDTH{in_ch.value[31]}}, in_ch.value};
  assign value_in   = value_wide[DATA_WIDTH-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign table_full  = (count_r == CW'(DEPTH));
  assign table_empty = (count_r == '0);
  assign query_go    = in_accept && (in_ch.cmd == CMD_QUERY) && !table_empty;

  // entry table
  sbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (value_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read entry against query
  sbs_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .entry (ram_rdata),
    .query (query_r),
    .tol   (tol_r),
    .flags (flags)
  );

  assign tol_hit = !flags.over && !flags.under;

  // search bounds and midpoints
  assign cnt_m1_w  = count_r - CW'(1);
  assign hi_init   = cnt_m1_w[AW-1:0];
  assign lo_up     = CW'(mid_r) + CW'(1);
  assign hi_dn     = mid_r - AW'(1);
  assign walk_dn   = mid_r - AW'(2);
  assign sum_init  = (CW+1)'(hi_init);
  assign sum_right = (CW+1)'(lo_up) + (CW+1)'(hi_r);
  assign sum_left  = (CW+1)'(lo_r) + (CW+1)'(hi_dn);
  assign sh_init   = sum_init >> 1;
  assign sh_right  = sum_right >> 1;
  assign sh_left   = sum_left >> 1;
  assign mid_init  = sh_init[AW-1:0];
  assign mid_right = sh_right[AW-1:0];
  assign mid_left  = sh_left[AW-1:0];

  assign go_right  = flags.less;
  assign right_end = lo_up > CW'(hi_r);
  assign left_end  = (mid_r == '0) || (lo_r > CW'(hi_dn));

  // no match: neighbors of the insertion point
  assign nf_lo    = go_right ? lo_up : lo_r;
  assign nf_lo_m1 = (nf_lo != '0) ? (nf_lo - CW'(1)) : '0;
  assign nf_lower = nf_lo_m1[AW-1:0];
  assign nf_upper = (nf_lo < count_r) ? nf_lo[AW-1:0] : hi_init;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_go) begin
          state_nxt = S_FIRST;
        end else if (in_accept) begin
          state_nxt = S_OUT;
        end
      end
      S_FIRST: begin
        state_nxt = flags.over ? S_OUT : S_LAST;
      end
      S_LAST: begin
        state_nxt = flags.under ? S_OUT : S_PROBE;
      end
      S_PROBE: begin
        if (tol_hit) begin
          state_nxt = (mid_r == '0) ? S_OUT : S_WALK;
        end else if (go_right ? right_end : left_end) begin
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (!tol_hit || (hi_dn == '0)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    count_nxt       = count_r;
    query_nxt       = query_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    res_status_nxt  = res_status_r;
    res_lower_nxt   = res_lower_r;
    res_upper_nxt   = res_upper_r;
    res_matched_nxt = res_matched_r;
    ram_we          = 1'b0;
    ram_raddr       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          query_nxt       = value_in;
          res_status_nxt  = ST_LOAD_OK;
          res_lower_nxt   = '0;
          res_upper_nxt   = '0;
          res_matched_nxt = 1'b0;
          case (in_ch.cmd)
            CMD_APPEND: begin
              if (table_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_QUERY: begin
              if (table_empty) begin
                res_status_nxt = ST_EMPTY;
              end
            end
            CMD_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      S_FIRST: begin
        ram_raddr = hi_init;
        if (flags.over) begin
          res_status_nxt = ST_BELOW;
        end
      end
      S_LAST: begin
        ram_raddr = mid_init;
        lo_nxt    = '0;
        hi_nxt    = hi_init;
        mid_nxt   = mid_init;
        if (flags.under) begin
          res_status_nxt = ST_ABOVE;
        end
      end
      S_PROBE: begin
        res_status_nxt = ST_BRACKET;
        if (tol_hit) begin
          ram_raddr       = hi_dn;
          res_lower_nxt   = mid_r;
          res_upper_nxt   = mid_r;
          res_matched_nxt = 1'b1;
        end else if (go_right) begin
          ram_raddr     = mid_right;
          lo_nxt        = lo_up;
          mid_nxt       = mid_right;
          res_lower_nxt = nf_lower;
          res_upper_nxt = nf_upper;
        end else begin
          ram_raddr     = mid_left;
          hi_nxt        = hi_dn;
          mid_nxt       = mid_left;
          res_lower_nxt = nf_lower;
          res_upper_nxt = nf_upper;
        end
      end
      S_WALK: begin
        ram_raddr = walk_dn;
        if (tol_hit) begin
          mid_nxt       = hi_dn;
          res_lower_nxt = hi_dn;
          res_upper_nxt = hi_dn;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk) begin
    query_r       <= query_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    res_status_r  <= res_status_nxt;
    res_lower_r   <= res_lower_nxt;
    res_upper_r   <= res_upper_nxt;
    res_matched_r <= res_matched_nxt;
  end

  // output register, indices reported modulo the field width
  assign lower_wide = (AW+IDX_W)'(res_lower_r);
  assign upper_wide = (AW+IDX_W)'(res_upper_r);

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_status_r  <= res_status_r;
      out_lower_r   <= lower_wide[IDX_W-1:0];
      out_upper_r   <= upper_wide[IDX_W-1:0];
      out_matched_r <= res_matched_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.lower_index = out_lower_r;
  assign out_ch.upper_index = out_upper_r;
  assign out_ch.matched     = out_matched_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE) && !table_full)
    else $error("table write outside idle or when full");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r <= CW'(hi_r)) && (CW'(mid_r) < count_r))
    else $error("probe outside search range");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (mid_r != '0))
    else $error("walk-back past first entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

endmodule

// ===== verif/sorted_table_bracket_search_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_table_bracket_search: self-checking, with its own table predictor.
// Depends on sbs_pkg, sbs_in_if / sbs_out_if and the sorted_table_bracket_search RTL.
module sorted_table_bracket_search_tb;
  import sbs_pkg::*;

  localparam int TBL_DEPTH    = 1024;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h80000000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFFFFFF;
  localparam logic [CMD_W-1:0]        CMD_SPARE = 2'd3;  // unused code, answered as load ok

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    lower_index;
    logic [IDX_W-1:0]    upper_index;
    logic                matched;
  } search_answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_wdata;

  sbs_in_if  cmd_if();
  sbs_out_if ans_if();

  sorted_table_bracket_search u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_if),
    .out_ch   (ans_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state: table copy, entry count and tolerance
  logic signed [VAL_W-1:0] stored_entries [TBL_DEPTH];
  int                      entry_count = 0;
  longint                  tol_value = 0;

  cmd_word_t      cmd_backlog[$];
  search_answer_t expected_answers[$];
  cmd_word_t      next_word;

  int          words_queued = 0;
  int          words_taken = 0;
  int          fail_count = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          hold_at = -1;
  int          hold_left = 0;
  bit          hold_fired = 1'b0;
  logic        in_fire = 1'b0;
  int unsigned cycle_count = 0;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint gap_of(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // expected answer for one accepted word; advances the predictor state
  function automatic search_answer_t predict_answer(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [VAL_W-1:0] value);
    search_answer_t ans;
    longint q, first_e, last_e, probe;
    int lo, hi, mid;
    bit found;
    ans = '0;
    ans.status = ST_LOAD_OK;
    q = value;
    case (cmd)
      CMD_APPEND: begin
        if (entry_count < TBL_DEPTH) begin
          stored_entries[entry_count] = value;
          entry_count++;
        end else begin
          ans.status = ST_FULL;
        end
      end
      CMD_CLEAR: entry_count = 0;
      CMD_QUERY: begin
        if (entry_count == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          first_e = stored_entries[0];
          last_e = stored_entries[entry_count-1];
          if (q < first_e && first_e - q > tol_value) begin
            ans.status = ST_BELOW;
          end else if (q > last_e && q - last_e > tol_value) begin
            ans.status = ST_ABOVE;
          end else begin
            ans.status = ST_BRACKET;
            lo = 0;
            hi = entry_count - 1;
            found = 1'b0;
            mid = 0;
            while (lo <= hi && !found) begin
              mid = lo + (hi - lo) / 2;
              probe = stored_entries[mid];
              if (gap_of(probe, q) <= tol_value) begin
                // step back to the first entry within tolerance
                while (mid > 0 && gap_of(stored_entries[mid-1], q) <= tol_value) mid--;
                found = 1'b1;
              end else if (probe < q) begin
                lo = mid + 1;
              end else begin
                hi = mid - 1;
              end
            end
            if (found) begin
              ans.lower_index = IDX_W'(mid);
              ans.upper_index = IDX_W'(mid);
              ans.matched = 1'b1;
            end else begin
              ans.lower_index = IDX_W'((lo > 0) ? lo - 1 : 0);
              ans.upper_index = IDX_W'((lo < entry_count) ? lo : entry_count - 1);
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    search_answer_t want, got;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= cmd_if.valid && cmd_if.ready;
      if (cmd_if.valid && cmd_if.ready) begin
        expected_answers.push_back(predict_answer(cmd_if.cmd, cmd_if.value));
        words_taken++;
      end
      if (ans_if.valid && ans_if.ready) begin
        got = {ans_if.status, ans_if.lower_index, ans_if.upper_index, ans_if.matched};
        if (expected_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected answer word: status %0d lower %0d upper %0d matched %0b",
                     got.status, got.lower_index, got.upper_index, got.matched);
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status || got.lower_index !== want.lower_index ||
              got.upper_index !== want.upper_index || got.matched !== want.matched) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("answer mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       want.status, want.lower_index, want.upper_index, want.matched,
                       got.status, got.lower_index, got.upper_index, got.matched);
          end
        end
      end
    end
  end

  // command driver: holds a word until taken, idles at random between words
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
      cmd_if.cmd <= CMD_APPEND;
      cmd_if.value <= '0;
    end else if (!cmd_if.valid || in_fire) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        next_word = cmd_backlog.pop_front();
        cmd_if.valid <= 1'b1;
        cmd_if.cmd <= next_word.cmd;
        cmd_if.value <= next_word.value;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started once when the taken count reaches hold_at
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_fired && words_taken == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end
  end

  // answer receiver
  always @(negedge clk) begin
    if (!rst_n) ans_if.ready <= 1'b0;
    else ans_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= out_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return VAL_MAX;
    if (v < -64'sd2147483648) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] value);
    cmd_word_t w;
    w.cmd = cmd;
    w.value = value;
    cmd_backlog.push_back(w);
    words_queued++;
  endtask

  // wait until every word is taken and answered
  task automatic wait_idle();
    while (words_taken != words_queued || expected_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] t);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    tol_value = t;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
  endtask

  function automatic longint next_step(input int unsigned max_step);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;  // duplicate entry
    if (r < 60) return $urandom_range(1, (max_step < 32'h3FFFF) ? max_step : 32'h3FFFF);
    return $urandom_range(1, max_step);
  endfunction

  // query value around an entry: exact, at or just past the tolerance, or a small offset
  function automatic logic signed [VAL_W-1:0] near_value(input longint base);
    case ($urandom_range(0, 5))
      0: return clamp_q16(base);
      1: return clamp_q16(base + tol_value);
      2: return clamp_q16(base - tol_value);
      3: return clamp_q16(base + tol_value + 1);
      4: return clamp_q16(base - tol_value - 1);
      default: return clamp_q16(base + longint'($urandom_range(0, 32'h1FFFE)) - 32'hFFFF);
    endcase
  endfunction

  // clear, load an ascending table, then query it
  task automatic build_and_probe(input int n_entries, input int n_queries,
                                 input int unsigned max_step);
    longint vals[$];
    longint cur;
    logic signed [VAL_W-1:0] rnd;
    int r;
    rnd = $urandom;
    queue_word(CMD_CLEAR, rnd);
    rnd = $urandom;
    if (n_entries > 64 || $urandom_range(0, 9) == 0)
      cur = -64'sd2147483648 + $urandom_range(0, 16'hFFFF);
    else
      cur = rnd;
    for (int i = 0; i < n_entries; i++) begin
      if (vals.size() < TBL_DEPTH) vals.push_back(cur);
      queue_word(CMD_APPEND, clamp_q16(cur));
      cur = cur + next_step(max_step);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
    for (int j = 0; j < n_queries; j++) begin
      r = $urandom_range(0, 99);
      rnd = $urandom;
      if (r < 60)
        queue_word(CMD_QUERY, near_value(vals[$urandom_range(0, vals.size() - 1)]));
      else if (r < 70)
        queue_word(CMD_QUERY, clamp_q16(vals[0] - tol_value - 1 - $urandom_range(0, 16'hFFFF)));
      else if (r < 80)
        queue_word(CMD_QUERY,
                   clamp_q16(vals[vals.size()-1] + tol_value + 1 + $urandom_range(0, 16'hFFFF)));
      else if (r < 90)
        queue_word(CMD_QUERY, rnd);
      else
        queue_word(CMD_QUERY, $urandom_range(0, 1) ? VAL_MAX : VAL_MIN);
    end
  endtask

  // random words of any command, the unused code included
  task automatic scatter_words(input int n);
    logic signed [VAL_W-1:0] rnd;
    for (int i = 0; i < n; i++) begin
      rnd = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        queue_word(CMD_CLEAR, rnd);
        queue_word(CMD_QUERY, rnd);
      end else begin
        queue_word(CMD_W'($urandom_range(0, 3)), rnd);
      end
    end
  endtask

  // unsorted appends on top of whatever is loaded, then queries
  task automatic unsorted_probe(input int n);
    logic signed [VAL_W-1:0] rnd;
    for (int i = 0; i < n; i++) begin
      rnd = $urandom;
      queue_word(CMD_APPEND, rnd);
    end
    for (int i = 0; i < n; i++) begin
      rnd = $urandom;
      queue_word(CMD_QUERY, rnd);
    end
  endtask

  task automatic random_burst(input int n_words);
    int target, r;
    target = words_queued + n_words;
    while (words_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        build_and_probe($urandom_range(1, 24), $urandom_range(2, 10), 32'hFFFFFF);
      else if (r < 87)
        scatter_words($urandom_range(1, 6));
      else
        unsorted_probe($urandom_range(1, 4));
    end
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(13, 80);

    // directed, tolerance at its reset value of zero: empty table, extremes,
    // walk back over equal entries, bracket without match, unused command, clear
    queue_word(CMD_QUERY, 32'h00050000);
    queue_word(CMD_APPEND, VAL_MIN);
    queue_word(CMD_APPEND, 32'hFFFF0000);
    queue_word(CMD_APPEND, 32'h00000000);
    queue_word(CMD_APPEND, 32'h00000000);
    queue_word(CMD_APPEND, 32'h00000000);
    queue_word(CMD_APPEND, 32'h00010000);
    queue_word(CMD_APPEND, VAL_MAX);
    queue_word(CMD_QUERY, 32'h00000000);
    queue_word(CMD_QUERY, VAL_MIN);
    queue_word(CMD_QUERY, VAL_MAX);
    queue_word(CMD_QUERY, 32'h00008000);
    queue_word(CMD_QUERY, 32'h80000001);
    queue_word(CMD_SPARE, 32'h00005A5A);
    queue_word(CMD_CLEAR, 32'h00000000);
    queue_word(CMD_APPEND, 32'h00010000);
    queue_word(CMD_APPEND, 32'h00020000);
    queue_word(CMD_APPEND, 32'h00030000);
    wait_idle();

    // directed, small tolerance: edges of the range exactly at and one past tolerance
    set_tolerance(31'h100);
    queue_word(CMD_QUERY, 32'h0000FF00);
    queue_word(CMD_QUERY, 32'h0000FEFF);
    queue_word(CMD_QUERY, 32'h00030100);
    queue_word(CMD_QUERY, 32'h00030101);
    queue_word(CMD_QUERY, 32'h00018000);
    queue_word(CMD_QUERY, 32'h0001FF00);
    wait_idle();

    // random part, slow receiver
    set_tolerance(31'h0);
    random_burst(110);
    wait_idle();
    set_tolerance(31'h7FFFFFFF);
    random_burst(110);
    wait_idle();

    // slow sender
    set_idling(80, 13);
    set_tolerance(31'h10000);
    random_burst(110);
    wait_idle();
    set_tolerance(TOL_W'($urandom_range(0, 32'hFFFFF)));
    random_burst(110);
    wait_idle();

    // no idling; one long receiver hold-off fills the block and stalls its input
    set_idling(0, 0);
    set_tolerance(31'h1);
    hold_at = words_taken + 30;
    random_burst(110);
    wait_idle();
    set_tolerance(TOL_W'($urandom));
    random_burst(110);
    wait_idle();

    // full table, appends past capacity, then an empty query after a clear
    set_tolerance(TOL_W'($urandom_range(0, 16'hFFFF)));
    build_and_probe(TBL_DEPTH + 4, 60, 32'h3FFFFF);
    queue_word(CMD_CLEAR, 32'h00000000);
    queue_word(CMD_QUERY, 32'h00000000);
    wait_idle();

    repeat (20) @(negedge clk);
    if (expected_answers.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbs_pkg.sv
rtl/sbs_if.sv
rtl/sbs_ram.sv
rtl/sbs_cmp.sv
rtl/sorted_table_bracket_search.sv
verif/sorted_table_bracket_search_tb.sv
